### rtl/core/cns_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cns_pkg: shared types and constants for the cell neighbour stencil
// Request and result payloads, register codes and grid bounds.
// ----------------------------------------------------------------------------
package cns_pkg;

  localparam int MAX_DIM   = 64;
  localparam int DIM_CAP   = (MAX_DIM < 64) ? MAX_DIM : 64;
  localparam int DIM_HI    = (DIM_CAP < 3) ? 3 : DIM_CAP;
  localparam int DIM_LO    = 3;

  localparam int DIM_W     = 7;
  localparam int COORD_W   = 6;
  localparam int IDX_W     = 12;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam logic [DIM_W-1:0] DIM_HI_V = DIM_HI[DIM_W-1:0];
  localparam logic [DIM_W-1:0] DIM_LO_V = DIM_LO[DIM_W-1:0];

  localparam logic [DIM_W-1:0] COLS_RST = 7'd8;
  localparam logic [DIM_W-1:0] ROWS_RST = 7'd8;
  localparam logic             WRAP_RST = 1'b1;

  localparam logic [1:0] REG_GRID_COLS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [1:0] REG_WRAP_MODE = 2'd2;

  typedef struct packed {
    logic [COORD_W-1:0] cell_col;
    logic [COORD_W-1:0] cell_row;
  } cns_in_t;

  typedef struct packed {
    logic [IDX_W-1:0] neighbour_cell;
    logic             last;
    logic             bad_cell;
  } cns_out_t;

  function automatic logic [DIM_W-1:0] dim_limit(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    res = v;
    if (v < DIM_LO_V) res = DIM_LO_V;
    else if (v > DIM_HI_V) res = DIM_HI_V;
    return res;
  endfunction

endpackage
`default_nettype wire

### rtl/core/cell_neighbour_stencil_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cell_neighbour_stencil_top: 3x3 neighbour index generator for a 2D grid
// Takes a centre cell and issues the linear indices of its neighbourhood in
// raster order, with periodic or open borders.
// ----------------------------------------------------------------------------
//  channel  ports                              payload
//  request  in_valid / in_ready / in_data      cns_in_t  (cell_col, cell_row)
//  result   out_valid / out_ready / out_data   cns_out_t (neighbour_cell, last, bad_cell)
//  config   psel penable pwrite paddr pwdata   grid_cols, grid_rows, wrap_mode
//
//  One result per cycle from the stencil register while the output is not stalled;
//  a request yields 1, 4, 6 or 9 results and occupies the register until its last
//  result issues, and the next request is taken in the cycle that result issues.
//  Synchronous active-low reset clears the stage and output valid and loads
//  the register defaults. A stalled output register holds the stage.
// ----------------------------------------------------------------------------
module cell_neighbour_stencil_top
  import cns_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire cns_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cns_out_t               out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [DIM_W-1:0] grid_cols_r;
  logic [DIM_W-1:0] grid_rows_r;
  logic             wrap_mode_r;

  logic             busy_r;
  logic [8:0]       mask_r;
  logic             bad_r;
  logic [COORD_W-1:0] rm_r, rc_r, rp_r;
  logic [COORD_W-1:0] cm_r, cc_r, cp_r;

  logic             out_valid_r;
  cns_out_t         out_data_r;

  logic [DIM_W-1:0] cols_eff, rows_eff;
  logic             cfg_wr;
  logic             accept;
  logic             emit;
  logic             sel_last;
  logic [8:0]       mask_nxt;
  logic [3:0]       pos;
  logic [COORD_W-1:0] r_sel, c_sel;
  logic [IDX_W-1:0] lin;

  logic               in_bad;
  logic [COORD_W-1:0] in_rm, in_rp, in_cm, in_cp;
  logic [2:0]         row_ok, col_ok;
  logic [8:0]         in_mask;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cols_eff = dim_limit(grid_cols_r);
  assign rows_eff = dim_limit(grid_rows_r);

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_GRID_COLS: prdata = {{(DATA_W-DIM_W){1'b0}}, grid_cols_r};
      REG_GRID_ROWS: prdata = {{(DATA_W-DIM_W){1'b0}}, grid_rows_r};
      REG_WRAP_MODE: prdata = {{(DATA_W-1){1'b0}}, wrap_mode_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_cols_r <= COLS_RST;
      grid_rows_r <= ROWS_RST;
      wrap_mode_r <= WRAP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_GRID_COLS: grid_cols_r <= pwdata[DIM_W-1:0];
        REG_GRID_ROWS: grid_rows_r <= pwdata[DIM_W-1:0];
        REG_WRAP_MODE: wrap_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // request decode: neighbour rows/cols and which of the nine exist
  always_comb begin
    in_bad = ({1'b0, in_data.cell_col} >= cols_eff) ||
             ({1'b0, in_data.cell_row} >= rows_eff);
    in_rm  = (in_data.cell_row == '0) ? COORD_W'(rows_eff - 7'd1)
                                      : in_data.cell_row - 6'd1;
    in_rp  = ({1'b0, in_data.cell_row} == rows_eff - 7'd1) ? '0
                                      : in_data.cell_row + 6'd1;
    in_cm  = (in_data.cell_col == '0) ? COORD_W'(cols_eff - 7'd1)
                                      : in_data.cell_col - 6'd1;
    in_cp  = ({1'b0, in_data.cell_col} == cols_eff - 7'd1) ? '0
                                      : in_data.cell_col + 6'd1;
    row_ok = {wrap_mode_r || ({1'b0, in_data.cell_row} != rows_eff - 7'd1),
              1'b1,
              wrap_mode_r || (in_data.cell_row != '0)};
    col_ok = {wrap_mode_r || ({1'b0, in_data.cell_col} != cols_eff - 7'd1),
              1'b1,
              wrap_mode_r || (in_data.cell_col != '0)};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        in_mask[i*3+j] = row_ok[i] && col_ok[j];
      end
    end
    if (in_bad) in_mask = 9'd1;
  end

  // lowest remaining position
  always_comb begin
    pos = 4'd0;
    for (int i = 8; i >= 0; i--) begin
      if (mask_r[i]) pos = 4'(i);
    end
  end

  always_comb begin
    r_sel = rc_r;
    c_sel = cc_r;
    unique case (pos)
      4'd0:    begin r_sel = rm_r; c_sel = cm_r; end
      4'd1:    begin r_sel = rm_r; c_sel = cc_r; end
      4'd2:    begin r_sel = rm_r; c_sel = cp_r; end
      4'd3:    begin r_sel = rc_r; c_sel = cm_r; end
      4'd4:    begin r_sel = rc_r; c_sel = cc_r; end
      4'd5:    begin r_sel = rc_r; c_sel = cp_r; end
      4'd6:    begin r_sel = rp_r; c_sel = cm_r; end
      4'd7:    begin r_sel = rp_r; c_sel = cc_r; end
      4'd8:    begin r_sel = rp_r; c_sel = cp_r; end
      default: begin r_sel = rc_r; c_sel = cc_r; end
    endcase
  end

  assign lin      = {6'd0, r_sel} * {5'd0, cols_eff} + {6'd0, c_sel};
  assign mask_nxt = mask_r & (mask_r - 9'd1);
  assign sel_last = (mask_nxt == '0);
  assign emit     = busy_r && (!out_valid_r || out_ready);
  assign in_ready = !busy_r || (emit && sel_last);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (emit && sel_last) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask_r <= in_mask;
      bad_r  <= in_bad;
      rm_r   <= in_rm;
      rc_r   <= in_data.cell_row;
      rp_r   <= in_rp;
      cm_r   <= in_cm;
      cc_r   <= in_data.cell_col;
      cp_r   <= in_cp;
    end else if (emit) begin
      mask_r <= mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.neighbour_cell <= bad_r ? '0 : lin;
      out_data_r.last           <= sel_last;
      out_data_r.bad_cell       <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: cell neighbour stencil checker
// Sends cell requests over valid/ready, writes the grid registers over the
// APB-style port between phases, predicts every neighbour index and compares
// each result in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import cns_pkg::*;

  localparam logic [1:0]        REG_UNUSED   = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_COLS    = {REG_GRID_COLS, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_ROWS    = {REG_GRID_ROWS, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_WRAP    = {REG_WRAP_MODE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_UNUSED  = {REG_UNUSED, 2'b00};
  localparam int                STALL_PCT    = 31;
  localparam int                HANG_LIMIT   = 5000;
  localparam int                MAX_PRINTS   = 40;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cns_in_t           in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cns_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // shadow copy of the grid registers
  logic [DIM_W-1:0]  grid_cols_q = COLS_RST;
  logic [DIM_W-1:0]  grid_rows_q = ROWS_RST;
  logic              wrap_q = WRAP_RST;

  cns_out_t          expected_cells[$];
  bit                stall_enable = 1'b1;
  int                err_count = 0;
  int                requests_sent = 0;
  int                bad_requests = 0;
  int                results_checked = 0;
  int                reg_writes = 0;
  int                hang_cycles = 0;

  cell_neighbour_stencil_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int clamp_dim(input logic [DIM_W-1:0] v);
    if (v < DIM_LO) return DIM_LO;
    if (v > DIM_HI) return DIM_HI;
    return int'(v);
  endfunction

  function automatic cns_in_t make_req(input int col, input int row);
    cns_in_t req;
    req.cell_col = col[COORD_W-1:0];
    req.cell_row = row[COORD_W-1:0];
    return req;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, msg);
    err_count++;
  endtask

  // expected neighbour indices for one centre cell, raster order
  task automatic predict_neighbourhood(input cns_in_t req);
    int       cols;
    int       rows;
    int       col;
    int       row;
    int       r;
    int       c;
    bit       row_ok;
    bit       col_ok;
    cns_out_t res;
    cns_out_t group[$];
    cols = clamp_dim(grid_cols_q);
    rows = clamp_dim(grid_rows_q);
    col  = int'(req.cell_col);
    row  = int'(req.cell_row);
    if (col >= cols || row >= rows) begin
      res.neighbour_cell = '0;
      res.last = 1'b1;
      res.bad_cell = 1'b1;
      expected_cells.push_back(res);
      bad_requests++;
      return;
    end
    for (int dr = -1; dr <= 1; dr++) begin
      row_ok = 1'b1;
      if (dr < 0) begin
        if (row == 0) begin
          row_ok = wrap_q;
          r = rows - 1;
        end else r = row - 1;
      end else if (dr > 0) begin
        if (row == rows - 1) begin
          row_ok = wrap_q;
          r = 0;
        end else r = row + 1;
      end else r = row;
      if (!row_ok) continue;
      for (int dc = -1; dc <= 1; dc++) begin
        col_ok = 1'b1;
        if (dc < 0) begin
          if (col == 0) begin
            col_ok = wrap_q;
            c = cols - 1;
          end else c = col - 1;
        end else if (dc > 0) begin
          if (col == cols - 1) begin
            col_ok = wrap_q;
            c = 0;
          end else c = col + 1;
        end else c = col;
        if (!col_ok) continue;
        res.neighbour_cell = IDX_W'(r * cols + c);
        res.last = 1'b0;
        res.bad_cell = 1'b0;
        group.push_back(res);
      end
    end
    foreach (group[i]) begin
      res = group[i];
      res.last = (i == group.size() - 1);
      expected_cells.push_back(res);
    end
  endtask

  task automatic send_request(input cns_in_t req);
    @(negedge clk);
    while (stall_enable && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    predict_neighbourhood(req);
    requests_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr[3:2])
      REG_GRID_COLS: grid_cols_q = value[DIM_W-1:0];
      REG_GRID_ROWS: grid_rows_q = value[DIM_W-1:0];
      REG_WRAP_MODE: wrap_q = value[0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_grid(input logic [DATA_W-1:0] cols, input logic [DATA_W-1:0] rows,
                          input logic [DATA_W-1:0] wrap);
    wait_idle();
    reg_write(ADDR_COLS, cols);
    reg_write(ADDR_ROWS, rows);
    reg_write(ADDR_WRAP, wrap);
  endtask

  task automatic random_requests(input int count);
    int cols;
    int rows;
    int col;
    int row;
    int pick;
    cols = clamp_dim(grid_cols_q);
    rows = clamp_dim(grid_rows_q);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        col = $urandom_range(63);
        row = $urandom_range(63);
      end else if (pick < 40) begin
        col = ($urandom_range(1) != 0) ? cols - 1 : 0;
        row = ($urandom_range(1) != 0) ? $urandom_range(rows - 1)
                                       : (($urandom_range(1) != 0) ? rows - 1 : 0);
      end else begin
        col = $urandom_range(cols - 1);
        row = $urandom_range(rows - 1);
      end
      send_request(make_req(col, row));
    end
  endtask

  task automatic test_reset_grid();
    send_request(make_req(0, 0));
    send_request(make_req(7, 7));
    send_request(make_req(0, 7));
    send_request(make_req(7, 0));
    send_request(make_req(3, 0));
    send_request(make_req(4, 4));
    send_request(make_req(8, 3));
    send_request(make_req(63, 63));
  endtask

  task automatic test_open_borders();
    set_grid(5, 4, 0);
    send_request(make_req(0, 0));
    send_request(make_req(4, 3));
    send_request(make_req(2, 0));
    send_request(make_req(0, 2));
    send_request(make_req(2, 1));
    send_request(make_req(3, 4));
    set_grid(32'h7F, 32'd100, 32'h2);
    send_request(make_req(63, 63));
    send_request(make_req(0, 0));
    send_request(make_req(63, 0));
    send_request(make_req(42, 21));
  endtask

  task automatic test_dim_clamp();
    set_grid(0, 2, 1);
    send_request(make_req(0, 0));
    send_request(make_req(2, 2));
    send_request(make_req(3, 1));
    wait_idle();
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    reg_write(ADDR_COLS, 32'hFFFF_FF83);
    send_request(make_req(1, 1));
    send_request(make_req(0, 2));
  endtask

  task automatic test_random_grids();
    set_grid(64, 64, 1);
    random_requests(25);
    set_grid(3, 3, 0);
    random_requests(25);
    set_grid(64, 3, 0);
    random_requests(20);
    repeat (3) begin
      set_grid($urandom_range(3, 64), $urandom_range(3, 64), $urandom_range(1));
      random_requests(20);
    end
    set_grid($urandom_range(127), $urandom_range(127), $urandom_range(1));
    random_requests(20);
  endtask

  task automatic test_back_to_back();
    set_grid(17, 11, $urandom_range(1));
    stall_enable = 1'b0;
    random_requests(30);
    wait_idle();
    stall_enable = 1'b1;
  endtask

  always @(negedge clk) begin
    out_ready <= !stall_enable || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin : result_check
    cns_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected result cell=%0d last=%0b bad=%0b",
                                  out_data.neighbour_cell, out_data.last, out_data.bad_cell));
      end else begin
        want = expected_cells.pop_front();
        results_checked++;
        if (out_data.neighbour_cell !== want.neighbour_cell || out_data.last !== want.last ||
            out_data.bad_cell !== want.bad_cell)
          report_mismatch($sformatf("cell=%0d last=%0b bad=%0b, expected cell=%0d last=%0b bad=%0b",
                                    out_data.neighbour_cell, out_data.last, out_data.bad_cell,
                                    want.neighbour_cell, want.last, want.bad_cell));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite && pready)) begin
      hang_cycles = 0;
    end else begin
      hang_cycles++;
      if (hang_cycles >= HANG_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results pending",
                 hang_cycles, expected_cells.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_grid();
    test_open_borders();
    test_dim_clamp();
    test_random_grids();
    test_back_to_back();
    wait_idle();
    repeat (16) @(posedge clk);
    if (expected_cells.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_cells.size()));
    $display("Sent %0d requests (%0d outside the grid) over open and periodic grids from 3x3",
             requests_sent, bad_requests);
    $display("to 64x64; checked %0d neighbour results after %0d register writes",
             results_checked, reg_writes);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
